/* rtl/rgb16_layer_blend_macros.svh */
// assertion macros shared by the rgb16 layer blend rtl
`ifndef RGB16_LAYER_BLEND_MACROS_SVH
`define RGB16_LAYER_BLEND_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RGB16LB_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RGB16LB_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rgb16lb_pkg.sv */
// shared types, constants and helpers for the rgb16 layer blend
`default_nettype none

package rgb16lb_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int PORT_BITS        = 16;
    localparam int OPACITY_BITS     = 17;
    localparam int OPACITY_FRAC     = 16;
    localparam int MODE_BITS        = 4;

    localparam logic [OPACITY_BITS-1:0] OPAQUE = 17'h10000;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD     = 4'd0,
        MODE_MUL     = 4'd1,
        MODE_SCREEN  = 4'd2,
        MODE_ALPHA   = 4'd3,
        MODE_XOR     = 4'd4,
        MODE_SUB     = 4'd5,
        MODE_DIFF    = 4'd6,
        MODE_LIGHTEN = 4'd7,
        MODE_DARKEN  = 4'd8
    } blend_mode_t;

    // per-stage load enables of the pixel pipeline
    typedef struct packed {
        logic s1_en;
        logic s2_en;
        logic s3_en;
        logic out_en;
    } pipe_en_t;

    // unknown codes fall back to additive
    function automatic blend_mode_t decode_mode(input logic [MODE_BITS-1:0] code);
        blend_mode_t m;
        unique case (code)
            MODE_MUL:     m = MODE_MUL;
            MODE_SCREEN:  m = MODE_SCREEN;
            MODE_ALPHA:   m = MODE_ALPHA;
            MODE_XOR:     m = MODE_XOR;
            MODE_SUB:     m = MODE_SUB;
            MODE_DIFF:    m = MODE_DIFF;
            MODE_LIGHTEN: m = MODE_LIGHTEN;
            MODE_DARKEN:  m = MODE_DARKEN;
            default:      m = MODE_ADD;
        endcase
        return m;
    endfunction

    // opacity above one saturates to fully opaque
    function automatic logic [OPACITY_BITS-1:0] clamp_opacity(
        input logic [OPACITY_BITS-1:0] op
    );
        return (op > OPAQUE) ? OPAQUE : op;
    endfunction

endpackage

`default_nettype wire

/* rtl/rgb16lb_chan.sv */
// one color channel of the blend datapath, four register stages
`default_nettype none

module rgb16lb_chan
    import rgb16lb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)(
    input  wire logic                    clk,
    input  wire pipe_en_t                en,
    input  wire logic [PORT_BITS-1:0]    base,
    input  wire logic [PORT_BITS-1:0]    overlay,
    input  wire blend_mode_t             mode_in,
    input  wire blend_mode_t             mode_s1,
    input  wire logic [OPACITY_BITS-1:0] op_s2,
    output logic [PORT_BITS-1:0]         result
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 2 * CB;
    localparam int SW = CB + OPACITY_BITS;

    // stage 0: mask and pick multiplier operands
    logic [CB-1:0] b0;
    logic [CB-1:0] o0;
    logic [CB-1:0] mul_a;
    logic [CB-1:0] mul_b;
    logic [PW-1:0] prod_next;

    // stage 1 registers
    logic [CB-1:0] b_s1_reg;
    logic [CB-1:0] o_s1_reg;
    logic [PW-1:0] prod_s1_reg;

    // stage 2 logic and registers
    logic [CB-1:0] prod_hi;
    logic [CB-1:0] target;
    logic [CB-1:0] x_next;
    logic          neg_next;
    logic [CB-1:0] b_s2_reg;
    logic [CB-1:0] x_s2_reg;
    logic          neg_s2_reg;

    // stage 3 logic and registers
    logic [SW-1:0] scaled_full;
    logic [CB-1:0] b_s3_reg;
    logic [CB-1:0] scaled_s3_reg;
    logic          neg_s3_reg;

    // stage 4 logic and output register
    logic [CB:0]   sum;
    logic [CB-1:0] res_next;
    logic [CB-1:0] res_reg;

    assign b0 = base[CB-1:0];
    assign o0 = overlay[CB-1:0];

    // screen multiplies the complements
    always_comb
    begin
        if (mode_in == MODE_SCREEN)
        begin
            mul_a = ~b0;
            mul_b = ~o0;
        end
        else
        begin
            mul_a = b0;
            mul_b = o0;
        end
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1_en)
        begin
            b_s1_reg    <= b0;
            o_s1_reg    <= o0;
            prod_s1_reg <= prod_next;
        end
    end

    assign prod_hi = prod_s1_reg[PW-1:CB];

    always_comb
    begin
        unique case (mode_s1)
            MODE_MUL:     target = prod_hi;
            MODE_SCREEN:  target = ~prod_hi;
            MODE_ALPHA:   target = o_s1_reg;
            MODE_XOR:     target = b_s1_reg ^ o_s1_reg;
            MODE_DIFF:    target = (b_s1_reg >= o_s1_reg) ? b_s1_reg - o_s1_reg
                                                          : o_s1_reg - b_s1_reg;
            MODE_LIGHTEN: target = (b_s1_reg >= o_s1_reg) ? b_s1_reg : o_s1_reg;
            MODE_DARKEN:  target = (b_s1_reg <= o_s1_reg) ? b_s1_reg : o_s1_reg;
            default:      target = o_s1_reg;
        endcase

        // add and subtract scale the overlay, the rest scale the distance to target
        if (mode_s1 == MODE_ADD || mode_s1 == MODE_SUB)
        begin
            x_next   = o_s1_reg;
            neg_next = (mode_s1 == MODE_SUB);
        end
        else
        begin
            neg_next = (target < b_s1_reg);
            x_next   = neg_next ? b_s1_reg - target : target - b_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2_en)
        begin
            b_s2_reg   <= b_s1_reg;
            x_s2_reg   <= x_next;
            neg_s2_reg <= neg_next;
        end
    end

    // opacity never exceeds one, so the scaled value fits the channel
    assign scaled_full = SW'(x_s2_reg) * SW'(op_s2);

    always_ff @(posedge clk)
    begin
        if (en.s3_en)
        begin
            b_s3_reg      <= b_s2_reg;
            scaled_s3_reg <= scaled_full[CB+OPACITY_FRAC-1:OPACITY_FRAC];
            neg_s3_reg    <= neg_s2_reg;
        end
    end

    assign sum = {1'b0, b_s3_reg} + {1'b0, scaled_s3_reg};

    // floor at zero going down, saturate at full scale going up
    always_comb
    begin
        if (neg_s3_reg)
        begin
            res_next = (scaled_s3_reg >= b_s3_reg) ? '0 : b_s3_reg - scaled_s3_reg;
        end
        else
        begin
            res_next = sum[CB] ? '1 : sum[CB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.out_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result = PORT_BITS'(res_reg);

endmodule

`default_nettype wire

/* rtl/rgb16lb_ctrl.sv */
// pipeline valid/stall control plus the shared mode and opacity stages
`default_nettype none

module rgb16lb_ctrl
    import rgb16lb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    input  wire logic [MODE_BITS-1:0]    req_type,
    input  wire logic [OPACITY_BITS-1:0] opacity_q16,
    output blend_mode_t                  mode_in,
    output blend_mode_t                  mode_s1,
    output logic [OPACITY_BITS-1:0]      op_s2,
    output pipe_en_t                     en
);

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic v3_reg;
    logic v3_next;
    logic vout_reg;
    logic vout_next;

    blend_mode_t              mode_s1_reg;
    logic [OPACITY_BITS-1:0]  op_s1_reg;
    logic [OPACITY_BITS-1:0]  op_s2_reg;

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        en.out_en = !vout_reg || !out_stall;
        en.s3_en  = !v3_reg || en.out_en;
        en.s2_en  = !v2_reg || en.s3_en;
        en.s1_en  = !v1_reg || en.s2_en;
    end

    always_comb
    begin
        v1_next   = en.s1_en  ? in_valid : v1_reg;
        v2_next   = en.s2_en  ? v1_reg   : v2_reg;
        v3_next   = en.s3_en  ? v2_reg   : v3_reg;
        vout_next = en.out_en ? v3_reg   : vout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            vout_reg <= vout_next;
        end
    end

    assign mode_in = decode_mode(req_type);

    always_ff @(posedge clk)
    begin
        if (en.s1_en)
        begin
            mode_s1_reg <= mode_in;
            op_s1_reg   <= clamp_opacity(opacity_q16);
        end
        if (en.s2_en)
        begin
            op_s2_reg <= op_s1_reg;
        end
    end

    assign mode_s1   = mode_s1_reg;
    assign op_s2     = op_s2_reg;
    assign in_stall  = !en.s1_en;
    assign out_valid = vout_reg;

`include "rgb16_layer_blend_macros.svh"

    `RGB16LB_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, (v1_reg && v2_reg && v3_reg && vout_reg), "input stalled while pipeline has a hole")
    `RGB16LB_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, (in_valid && !in_stall), v1_reg, "accepted transfer did not reach stage 1")
    `RGB16LB_ASSERT_NEXT(a_s3_holds, clk, rst_n, (v3_reg && !en.s3_en), v3_reg, "stalled stage 3 item lost")
    `RGB16LB_ASSERT_NEXT(a_out_follows_s3, clk, rst_n, en.out_en, (vout_reg == $past(v3_reg)), "output valid does not follow stage 3")

endmodule

`default_nettype wire

/* rtl/rgb16_layer_blend.sv */
// top level of the rgb16 layer blend: composites an overlay pixel onto a base pixel
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  -----------------------------------------
//  in        sink       in_valid / in_stall   base_*, overlay_*, req_type, opacity_q16
//  out       source     out_valid / out_stall out_red, out_green, out_blue
//
// one pixel per clock sustained while out_stall is low; out_valid rises once an input
// transfer has passed through the stage 1, 2 and 3 registers into the output register
// (register stages: operand multiply, target select, opacity multiply, mix)
// the opacity multiply and the channel multiply each own a full stage
// rst_n is asynchronous and active low; it clears only the stage valid bits
// each stage holds while full and blocked, so in_stall rises only when all
// four stages are full and out_stall is high
`default_nettype none

module rgb16_layer_blend
    import rgb16lb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // input pixel channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [PORT_BITS-1:0]    base_red,
    input  wire logic [PORT_BITS-1:0]    base_green,
    input  wire logic [PORT_BITS-1:0]    base_blue,
    input  wire logic [PORT_BITS-1:0]    overlay_red,
    input  wire logic [PORT_BITS-1:0]    overlay_green,
    input  wire logic [PORT_BITS-1:0]    overlay_blue,
    input  wire logic [MODE_BITS-1:0]    req_type,
    input  wire logic [OPACITY_BITS-1:0] opacity_q16,

    // blended pixel channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [PORT_BITS-1:0]         out_red,
    output logic [PORT_BITS-1:0]         out_green,
    output logic [PORT_BITS-1:0]         out_blue
);

    // decoded mode enters at stage 0 and is kept for the target select
    blend_mode_t             mode_in;
    blend_mode_t             mode_s1;
    // clamped opacity, delayed to line up with the opacity multiply
    logic [OPACITY_BITS-1:0] op_s2;
    pipe_en_t                en;

    rgb16lb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .req_type    (req_type),
        .opacity_q16 (opacity_q16),
        .mode_in     (mode_in),
        .mode_s1     (mode_s1),
        .op_s2       (op_s2),
        .en          (en)
    );

    // three identical channel datapaths share the control stages
    rgb16lb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chan_red (
        .clk     (clk),
        .en      (en),
        .base    (base_red),
        .overlay (overlay_red),
        .mode_in (mode_in),
        .mode_s1 (mode_s1),
        .op_s2   (op_s2),
        .result  (out_red)
    );

    rgb16lb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chan_green (
        .clk     (clk),
        .en      (en),
        .base    (base_green),
        .overlay (overlay_green),
        .mode_in (mode_in),
        .mode_s1 (mode_s1),
        .op_s2   (op_s2),
        .result  (out_green)
    );

    rgb16lb_chan #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chan_blue (
        .clk     (clk),
        .en      (en),
        .base    (base_blue),
        .overlay (overlay_blue),
        .mode_in (mode_in),
        .mode_s1 (mode_s1),
        .op_s2   (op_s2),
        .result  (out_blue)
    );

endmodule

`default_nettype wire

/* dv/rgb16_blend_checker.sv */
// checker for the rgb16 layer blend: predicts each blended pixel and compares it
module rgb16_blend_checker
    import rgb16lb_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [PORT_BITS-1:0]    base_red,
    input  logic [PORT_BITS-1:0]    base_green,
    input  logic [PORT_BITS-1:0]    base_blue,
    input  logic [PORT_BITS-1:0]    overlay_red,
    input  logic [PORT_BITS-1:0]    overlay_green,
    input  logic [PORT_BITS-1:0]    overlay_blue,
    input  logic [MODE_BITS-1:0]    req_type,
    input  logic [OPACITY_BITS-1:0] opacity_q16,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [PORT_BITS-1:0]    out_red,
    input  logic [PORT_BITS-1:0]    out_green,
    input  logic [PORT_BITS-1:0]    out_blue,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic [PORT_BITS-1:0] red;
        logic [PORT_BITS-1:0] green;
        logic [PORT_BITS-1:0] blue;
    } blended_px_t;

    blended_px_t expected_px[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // overlay or difference scaled by a q1.16 opacity, truncated
    function automatic bit [31:0] opacity_scale(input bit [31:0] v,
                                                input bit [OPACITY_BITS-1:0] op);
        bit [63:0] p;
        p = 64'(v) * 64'(op);
        return 32'(p >> OPACITY_FRAC);
    endfunction

    function automatic logic [PORT_BITS-1:0] blend_one(
        input logic [PORT_BITS-1:0]    b_in,
        input logic [PORT_BITS-1:0]    o_in,
        input logic [MODE_BITS-1:0]    code,
        input logic [OPACITY_BITS-1:0] op_in
    );
        bit [31:0]               full;
        bit [31:0]               b;
        bit [31:0]               o;
        bit [31:0]               t;
        bit [31:0]               s;
        bit [31:0]               r;
        bit [OPACITY_BITS-1:0]   op;
        full = (32'd1 << CHANNEL_BITS) - 32'd1;
        b    = 32'(b_in) & full;
        o    = 32'(o_in) & full;
        op   = (op_in > OPAQUE) ? OPAQUE : op_in;
        t    = 32'd0;
        case (code)
            MODE_MUL:     t = 32'((64'(b) * 64'(o)) >> CHANNEL_BITS);
            MODE_SCREEN:  t = full - 32'((64'(full - b) * 64'(full - o)) >> CHANNEL_BITS);
            MODE_ALPHA:   t = o;
            MODE_XOR:     t = b ^ o;
            MODE_DIFF:    t = (b >= o) ? b - o : o - b;
            MODE_LIGHTEN: t = (b >= o) ? b : o;
            MODE_DARKEN:  t = (b <= o) ? b : o;
            default:      t = 32'd0;
        endcase
        if (code == MODE_SUB)
        begin
            s = opacity_scale(o, op);
            r = (s >= b) ? 32'd0 : b - s;
        end
        else if (code == MODE_ADD || code > MODE_DARKEN)
        begin
            s = b + opacity_scale(o, op);
            r = (s > full) ? full : s;
        end
        else if (t >= b)
            r = b + opacity_scale(t - b, op);
        else
            r = b - opacity_scale(b - t, op);
        return PORT_BITS'(r & full);
    endfunction

    task automatic check_field(input string field, input logic [PORT_BITS-1:0] want_v,
                               input logic [PORT_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        blended_px_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_px.size() == 0)
                begin
                    $error("out_red/out_green/out_blue: expected no transfer, got %0d %0d %0d",
                           out_red, out_green, out_blue);
                    mismatches++;
                end
                else
                begin
                    want = expected_px.pop_front();
                    check_field("out_red", want.red, out_red);
                    check_field("out_green", want.green, out_green);
                    check_field("out_blue", want.blue, out_blue);
                end
            end
            if (in_valid && !in_stall)
            begin
                want.red   = blend_one(base_red, overlay_red, req_type, opacity_q16);
                want.green = blend_one(base_green, overlay_green, req_type, opacity_q16);
                want.blue  = blend_one(base_blue, overlay_blue, req_type, opacity_q16);
                expected_px.push_back(want);
            end
            outstanding = expected_px.size();
        end
    end

endmodule

/* dv/tb_rgb16_layer_blend.sv */
// testbench top for the rgb16 layer blend: stimulus, receiver stalls and verdict
module tb_rgb16_layer_blend;
    import rgb16lb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 8;     // pipeline is four deep

    // one input pixel request, index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][PORT_BITS-1:0] base_px;
        logic [2:0][PORT_BITS-1:0] overlay_px;
        logic [MODE_BITS-1:0]      mode;
        logic [OPACITY_BITS-1:0]   opacity;
    } pixel_req_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [PORT_BITS-1:0]    base_red;
    logic [PORT_BITS-1:0]    base_green;
    logic [PORT_BITS-1:0]    base_blue;
    logic [PORT_BITS-1:0]    overlay_red;
    logic [PORT_BITS-1:0]    overlay_green;
    logic [PORT_BITS-1:0]    overlay_blue;
    logic [MODE_BITS-1:0]    req_type;
    logic [OPACITY_BITS-1:0] opacity_q16;
    logic                    out_valid;
    logic                    out_stall;
    logic [PORT_BITS-1:0]    out_red;
    logic [PORT_BITS-1:0]    out_green;
    logic [PORT_BITS-1:0]    out_blue;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;

    rgb16_layer_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base_red      (base_red),
        .base_green    (base_green),
        .base_blue     (base_blue),
        .overlay_red   (overlay_red),
        .overlay_green (overlay_green),
        .overlay_blue  (overlay_blue),
        .req_type      (req_type),
        .opacity_q16   (opacity_q16),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue)
    );

    rgb16_blend_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base_red      (base_red),
        .base_green    (base_green),
        .base_blue     (base_blue),
        .overlay_red   (overlay_red),
        .overlay_green (overlay_green),
        .overlay_blue  (overlay_blue),
        .req_type      (req_type),
        .opacity_q16   (opacity_q16),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // free-running clock, period 10
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop in case the pipeline hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver back-pressure: runs of stall, free stretches and a toggling pattern
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            run = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat (run) @(negedge clk) out_stall = 1'b1;
                3:
                    repeat (run) @(negedge clk) out_stall = ~out_stall;
                4:
                    repeat ($urandom_range(20, 60)) @(negedge clk) out_stall = 1'b0;
                default:
                    repeat (run) @(negedge clk) out_stall = 1'b0;
            endcase
        end
    end

    // channel value: extremes now and then, otherwise any 16-bit code
    function automatic logic [PORT_BITS-1:0] pick_channel();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2, 3:    return '1;
            default: return PORT_BITS'($urandom());
        endcase
    endfunction

    function automatic pixel_req_t random_pixel();
        pixel_req_t px;
        for (int c = 0; c < 3; c++)
        begin
            px.base_px[c]    = pick_channel();
            px.overlay_px[c] = pick_channel();
        end
        // named modes mostly, the unused codes now and then
        if ($urandom_range(0, 9) == 0)
            px.mode = MODE_BITS'($urandom_range(MODE_DARKEN + 1, (1 << MODE_BITS) - 1));
        else
            px.mode = MODE_BITS'($urandom_range(MODE_ADD, MODE_DARKEN));
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       px.opacity = '0;
                    1:       px.opacity = OPACITY_BITS'(1);
                    2:       px.opacity = OPAQUE - OPACITY_BITS'(1);
                    default: px.opacity = OPAQUE;
                endcase
            end
            // above one, must saturate to opaque
            1:       px.opacity = OPACITY_BITS'($urandom_range(OPAQUE + 1, (1 << OPACITY_BITS) - 1));
            default: px.opacity = OPACITY_BITS'($urandom_range(0, OPAQUE));
        endcase
        return px;
    endfunction

    // one transfer on the input channel, with bursts and random gaps between them
    task automatic send_pixel(input pixel_req_t px);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            // an occasional long burst keeps the pipeline full for a while
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid      = 1'b1;
        base_red      = px.base_px[0];
        base_green    = px.base_px[1];
        base_blue     = px.base_px[2];
        overlay_red   = px.overlay_px[0];
        overlay_green = px.overlay_px[1];
        overlay_blue  = px.overlay_px[2];
        req_type      = px.mode;
        opacity_q16   = px.opacity;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold the input idle until every predicted pixel has come out
    task automatic wait_drained();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        pixel_req_t                  px;
        logic [OPACITY_BITS-1:0]     op_list [7];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        base_red      = '0;
        base_green    = '0;
        base_blue     = '0;
        overlay_red   = '0;
        overlay_green = '0;
        overlay_blue  = '0;
        req_type      = MODE_ADD;
        opacity_q16   = '0;
        op_list = '{'0, OPAQUE, '1, OPAQUE >> 1, OPACITY_BITS'(1),
                    OPAQUE - OPACITY_BITS'(1), OPAQUE + OPACITY_BITS'(1)};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every mode code, channel extremes, opacity extremes and above one
        for (int code = 0; code < (1 << MODE_BITS); code++)
        begin
            px.mode    = MODE_BITS'(code);
            px.opacity = op_list[code % 7];
            if (code % 2 == 0)
            begin
                px.base_px    = {16'h8000, 16'hffff, 16'h0000};
                px.overlay_px = {16'h7fff, 16'h0000, 16'hffff};
            end
            else
            begin
                px.base_px    = {16'h7fff, 16'h0000, 16'hffff};
                px.overlay_px = {16'h8000, 16'hffff, 16'h0000};
            end
            send_pixel(px);
        end

        // additive saturating at full scale
        px = '{base_px: '1, overlay_px: '1, mode: MODE_ADD, opacity: OPAQUE};
        send_pixel(px);
        // subtract flooring at zero
        px = '{base_px: '0, overlay_px: '1, mode: MODE_SUB, opacity: OPAQUE};
        send_pixel(px);
        // alpha pulling down with a tiny opacity, negative lerp truncates toward zero
        px = '{base_px: '1, overlay_px: '0, mode: MODE_ALPHA, opacity: OPACITY_BITS'(1)};
        send_pixel(px);
        // alpha fully opaque copies the overlay
        px = '{base_px: {16'h1234, 16'hfedc, 16'h0001}, overlay_px: {16'hffff, 16'h0000,
               16'habcd}, mode: MODE_ALPHA, opacity: '1};
        send_pixel(px);
        // screen and multiply of all ones
        px = '{base_px: '1, overlay_px: '1, mode: MODE_SCREEN, opacity: OPAQUE};
        send_pixel(px);
        px = '{base_px: '1, overlay_px: '1, mode: MODE_MUL, opacity: OPAQUE};
        send_pixel(px);

        // sender holds off until the pipeline is empty
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            send_pixel(random_pixel());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
